### hdl/qrm_pkg.sv
// Shared types and constants for the quaternion to rotation matrix block.
package qrm_pkg;

  localparam int FIELD_W        = 16;
  localparam int COMP_WIDTH_DEF = 16;
  localparam int PROD_W         = 2 * FIELD_W;
  localparam int SUM_W          = PROD_W + 1;
  localparam int NUM_W          = PROD_W + 2;
  localparam int QUO_W          = 15;
  localparam int DVD_W          = SUM_W + QUO_W + 1;
  localparam int DEN_W          = SUM_W + 1;
  localparam int REM_W          = DEN_W + 1;
  localparam int OUT_W          = 16;
  localparam int N_ENTRY        = 9;
  localparam int IN_DATA_W      = 4 * FIELD_W;
  localparam int OUT_DATA_W     = N_ENTRY * OUT_W;
  localparam logic [OUT_W-1:0] ONE_Q14 = 16'd16384;

  typedef struct packed {
    logic signed [PROD_W-1:0] ww;
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] zw;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yw;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] xw;
  } prod_t;

endpackage

### hdl/quaternion_to_rotation_matrix.sv
// Top level of the quaternion to rotation matrix block.
// Takes one quaternion per transfer and returns the nine Q1.14 entries of its
// normalized rotation matrix, one result per input, at a sustained rate of one
// item per clock while the output is not stalled. The products are registered
// at the accepting edge. The queue, the squared-norm stage and the numerator
// stage are each registered. The pipelined divider has a load stage, then one
// stage for each of the 15 quotient bits of every entry. Last comes the output
// register.
// An all-zero quaternion yields the identity matrix with tuser set.
module quaternion_to_rotation_matrix import qrm_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // quat_w, quat_x, quat_y, quat_z
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // row0_col0 .. row2_col2
  output logic                  m_axis_tuser_o   // degenerate
);

  logic  f_valid, f_ready, b_valid, b_ready;
  prod_t f_prod, b_prod;

  qrm_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_prod_o  (f_prod)
  );

  qrm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_prod),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_prod)
  );

  qrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_prod_i   (b_prod),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_degen_o (m_axis_tuser_o)
  );

endmodule

### hdl/qrm_front.sv
// Front part: accepts quaternions and forms the ten component products.
module qrm_front import qrm_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output prod_t                out_prod_o
);

  localparam int EFF_W = (COMP_WIDTH > FIELD_W) ? FIELD_W : ((COMP_WIDTH < 1) ? 1 : COMP_WIDTH);
  localparam int SH    = FIELD_W - EFF_W;

  logic               vld_q;
  prod_t              prod_q, prod_d;
  logic signed [FIELD_W-1:0] w, x, y, z;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_prod_o  = prod_q;

  always_comb begin
    w = $signed(in_data_i[FIELD_W-1:0] << SH) >>> SH;
    x = $signed(in_data_i[2*FIELD_W-1:FIELD_W] << SH) >>> SH;
    y = $signed(in_data_i[3*FIELD_W-1:2*FIELD_W] << SH) >>> SH;
    z = $signed(in_data_i[4*FIELD_W-1:3*FIELD_W] << SH) >>> SH;
    prod_d.ww = w * w;
    prod_d.xx = x * x;
    prod_d.yy = y * y;
    prod_d.zz = z * z;
    prod_d.xy = x * y;
    prod_d.zw = z * w;
    prod_d.xz = x * z;
    prod_d.yw = y * w;
    prod_d.yz = y * z;
    prod_d.xw = x * w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      prod_q <= prod_d;
    end
  end

endmodule

### hdl/qrm_fifo.sv
// Two-entry queue between the front and back parts.
module qrm_fifo import qrm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  prod_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output prod_t pop_data_o
);

  prod_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### hdl/qrm_div.sv
// Pipelined restoring divider giving one rounded Q1.14 matrix entry per lane.
module qrm_div import qrm_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DVD_W-1:0]  dvd_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              neg_i,
  output logic [OUT_W-1:0]  res_o
);

  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0] lo_q  [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic             neg_q [QUO_W+1];
  logic [REM_W-1:0] trial [QUO_W];
  logic             fit   [QUO_W];
  logic [OUT_W-1:0] mag;

  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      trial[i] = {rem_q[i], lo_q[i][QUO_W-1]};
      fit[i]   = (trial[i] >= {1'b0, den_q[i]});
    end
    mag   = (quo_q[QUO_W] > QUO_W'(ONE_Q14)) ? ONE_Q14 : {1'b0, quo_q[QUO_W]};
    res_o = neg_q[QUO_W] ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= dvd_i[DVD_W-1:QUO_W];
      lo_q[0]  <= dvd_i[QUO_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      for (int i = 0; i < QUO_W; i++) begin
        rem_q[i+1] <= fit[i] ? DEN_W'(trial[i] - {1'b0, den_q[i]}) : trial[i][DEN_W-1:0];
        lo_q[i+1]  <= {lo_q[i][QUO_W-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][QUO_W-2:0], fit[i]};
        den_q[i+1] <= den_q[i];
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

endmodule

### hdl/qrm_back.sv
// Back part: forms numerators, divides by the squared norm and drives results.
module qrm_back import qrm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  prod_t                 in_prod_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_degen_o
);

  localparam int DEPTH = QUO_W + 4;

  logic                     vld_q [DEPTH];
  logic                     dgn_q [DEPTH];
  logic                     en;
  logic [SUM_W-1:0]         s_q;
  logic [PROD_W-1:0]        pair_q [3];
  logic signed [SUM_W-1:0]  cross_q [6];
  logic signed [NUM_W-1:0]  num [N_ENTRY];
  logic [SUM_W-1:0]         mag [N_ENTRY];
  logic [DVD_W-1:0]         dvd_q [N_ENTRY];
  logic [DEN_W-1:0]         den_q;
  logic                     neg_q [N_ENTRY];
  logic [OUT_W-1:0]         res [N_ENTRY];
  logic [OUT_DATA_W-1:0]    data_q;
  logic [OUT_DATA_W-1:0]    data_d;

  assign en          = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[DEPTH-1];
  assign out_data_o  = data_q;
  assign out_degen_o = dgn_q[DEPTH-1];

  always_comb begin
    num[0] = NUM_W'(s_q) - NUM_W'({pair_q[0], 1'b0});
    num[4] = NUM_W'(s_q) - NUM_W'({pair_q[1], 1'b0});
    num[8] = NUM_W'(s_q) - NUM_W'({pair_q[2], 1'b0});
    num[1] = NUM_W'(cross_q[0]) <<< 1;
    num[2] = NUM_W'(cross_q[1]) <<< 1;
    num[3] = NUM_W'(cross_q[2]) <<< 1;
    num[5] = NUM_W'(cross_q[3]) <<< 1;
    num[6] = NUM_W'(cross_q[4]) <<< 1;
    num[7] = NUM_W'(cross_q[5]) <<< 1;
    for (int i = 0; i < N_ENTRY; i++) begin
      mag[i] = num[i][NUM_W-1] ? SUM_W'(-num[i]) : SUM_W'(num[i]);
    end
    for (int i = 0; i < N_ENTRY; i++) begin
      if (dgn_q[DEPTH-2]) begin
        data_d[i*OUT_W +: OUT_W] = (i % 4 == 0) ? ONE_Q14 : '0;
      end else begin
        data_d[i*OUT_W +: OUT_W] = res[i];
      end
    end
  end

  for (genvar g = 0; g < N_ENTRY; g++) begin : g_lane
    qrm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .dvd_i (dvd_q[g]),
      .den_i (den_q),
      .neg_i (neg_q[g]),
      .res_o (res[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= SUM_W'($unsigned(in_prod_i.ww)) + SUM_W'($unsigned(in_prod_i.xx))
           + SUM_W'($unsigned(in_prod_i.yy)) + SUM_W'($unsigned(in_prod_i.zz));
      pair_q[0]  <= $unsigned(in_prod_i.yy) + $unsigned(in_prod_i.zz);
      pair_q[1]  <= $unsigned(in_prod_i.xx) + $unsigned(in_prod_i.zz);
      pair_q[2]  <= $unsigned(in_prod_i.xx) + $unsigned(in_prod_i.yy);
      cross_q[0] <= SUM_W'(in_prod_i.xy) - SUM_W'(in_prod_i.zw);
      cross_q[1] <= SUM_W'(in_prod_i.xz) + SUM_W'(in_prod_i.yw);
      cross_q[2] <= SUM_W'(in_prod_i.xy) + SUM_W'(in_prod_i.zw);
      cross_q[3] <= SUM_W'(in_prod_i.yz) - SUM_W'(in_prod_i.xw);
      cross_q[4] <= SUM_W'(in_prod_i.xz) - SUM_W'(in_prod_i.yw);
      cross_q[5] <= SUM_W'(in_prod_i.yz) + SUM_W'(in_prod_i.xw);
      dgn_q[0]   <= 1'b0;
      dgn_q[1]   <= (s_q == '0);
      for (int i = 2; i < DEPTH; i++) dgn_q[i] <= dgn_q[i-1];
      den_q <= {s_q, 1'b0};
      for (int i = 0; i < N_ENTRY; i++) begin
        dvd_q[i] <= {mag[i], QUO_W'(0)} + DVD_W'(s_q);
        neg_q[i] <= num[i][NUM_W-1];
      end
      data_q <= data_d;
    end
  end

endmodule

### hdl/qrm_checker.sv
// Port-level checks for the quaternion to rotation matrix block.
module qrm_checker import qrm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tuser_o
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("Result valid during reset.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("Stalled result changed.");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[15:0] == ONE_Q14 && m_axis_tdata_o[79:64] == ONE_Q14 &&
      m_axis_tdata_o[143:128] == ONE_Q14 && m_axis_tdata_o[63:16] == '0 &&
      m_axis_tdata_o[127:80] == '0)
    else $error("Degenerate result is not the identity.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      $signed(m_axis_tdata_o[15:0]) <= 16'sd16384 &&
      $signed(m_axis_tdata_o[15:0]) >= -16'sd16384)
    else $error("Diagonal entry out of range.");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
